@@ hw/rtl/scbn_pkg.sv @@
// Shared types, widths and codes for the class-wise box suppression block.
`default_nettype none

package scbn_pkg;

  // Default sizes
  localparam int MAX_BOXES_DEF = 1024;
  localparam int MAX_OUT_DEF   = 64;

  // Field widths
  localparam int COORD_W  = 16;
  localparam int SCORE_W  = 16;
  localparam int CLASS_W  = 7;
  localparam int LIMIT_W  = 13;
  localparam int SCALE_W  = 16;
  localparam int THRESH_W = 16;
  localparam int OUT_W    = 20;

  // Geometry arithmetic widths (Q12.4 edges, one pixel is 16)
  localparam int EDGE_W   = COORD_W + 2;
  localparam int DIFF_W   = EDGE_W + 1;
  localparam int SPAN_W   = COORD_W + 1;
  localparam int AREA_W   = 2 * SPAN_W;
  localparam int UNION_W  = AREA_W + 1;
  localparam int PROD_W   = UNION_W + THRESH_W;
  localparam int ONE_PIXEL = 16;
  localparam int PASS_W   = $clog2(SCORE_W);

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_IOU_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_SCALE_X   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_SCALE_Y   = 3'd4;

  // Steps of one suppression slot; every cell advances on the last one
  localparam int PHASE_W = 3;
  localparam logic [PHASE_W-1:0] PH_EDGES  = 3'd0;
  localparam logic [PHASE_W-1:0] PH_INTER  = 3'd1;
  localparam logic [PHASE_W-1:0] PH_UNION  = 3'd2;
  localparam logic [PHASE_W-1:0] PH_PROD   = 3'd3;
  localparam logic [PHASE_W-1:0] PH_DECIDE = 3'd4;

  typedef struct packed {
    logic signed [COORD_W-1:0] box_left;
    logic signed [COORD_W-1:0] box_top;
    logic [COORD_W-1:0]        box_width;
    logic [COORD_W-1:0]        box_height;
    logic [SCORE_W-1:0]        box_score;
    logic [CLASS_W-1:0]        box_class;
    logic                      last_box;
  } box_in_t;

  typedef struct packed {
    logic [OUT_W-1:0]   out_left;
    logic [OUT_W-1:0]   out_top;
    logic [OUT_W-1:0]   out_right;
    logic [OUT_W-1:0]   out_bottom;
    logic [SCORE_W-1:0] out_score;
    logic [CLASS_W-1:0] out_class;
    logic               out_overflowed;
    logic               out_last;
  } box_out_t;

  // One stored box
  typedef struct packed {
    logic signed [COORD_W-1:0] left;
    logic signed [COORD_W-1:0] top;
    logic [COORD_W-1:0]        width;
    logic [COORD_W-1:0]        height;
    logic [SCORE_W-1:0]        score;
    logic [CLASS_W-1:0]        cls;
  } box_rec_t;

  // A ranked box on its way down the cell chain
  typedef struct packed {
    box_rec_t          rec;
    logic [AREA_W-1:0] area;
  } cand_t;

  typedef struct packed {
    logic [THRESH_W-1:0] iou_threshold;
    logic [LIMIT_W-1:0]  image_width;
    logic [LIMIT_W-1:0]  image_height;
    logic [SCALE_W-1:0]  inv_scale_x;
    logic [SCALE_W-1:0]  inv_scale_y;
  } cfg_t;

  typedef struct packed {
    logic               clear;
    logic               advance;
    logic               shift;
    logic [PHASE_W-1:0] phase;
  } chain_ctl_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_KICK,
    ST_SORT,
    ST_NMS,
    ST_CLAMP,
    ST_SCALE,
    ST_SEND
  } nms_state_t;

endpackage

`default_nettype wire

@@ hw/rtl/sorted_classwise_box_nms.sv @@
// Class-wise greedy box suppression: store, rank by score, suppress, emit survivors.
//
// Input channel box_valid/box_stall/box_item: one candidate box per cycle while
// loading; last_box closes the batch and the block stalls input until every
// survivor of the batch has been taken. Boxes beyond MAX_BOXES are dropped and
// flagged in out_overflowed of that batch's results.
// Output channel res_valid/res_stall/res_item: survivors in descending score
// order (ties in arrival order), at most MAX_OUT, out_last on the final one.
// A stalled result holds its payload until taken.
// Work after the last box of a batch of n stored boxes:
//   ranking, 16 one-bit radix passes over the score memory
//   suppression, one slot per rank (edges, intersection, union, product, decide)
//   through the MAX_OUT-cell chain, set by the multiply steps of the overlap test
//   emit: clamp, scale and send per survivor, the send held by receiver stall.
// The user must write configuration via cfg_we/cfg_index/cfg_data between batches; the block does not enforce it.
// Synchronous reset restores register defaults and empties the store.
`default_nettype none

module sorted_classwise_box_nms import scbn_pkg::*; #(
  parameter int MAX_BOXES = MAX_BOXES_DEF,
  parameter int MAX_OUT   = MAX_OUT_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  box_valid,
  output logic                       box_stall,
  input  wire box_in_t               box_item,
  output logic                       res_valid,
  input  wire logic                  res_stall,
  output box_out_t                   res_item,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W  = $clog2(MAX_BOXES);
  localparam int CNT_W  = $clog2(MAX_BOXES + 1);
  localparam int SLOT_W = $clog2(MAX_BOXES + MAX_OUT);

  nms_state_t         state, state_next;
  cfg_t               cfg;
  logic [PHASE_W-1:0] phase;
  logic [SLOT_W-1:0]  slot;
  logic [SLOT_W-1:0]  slot_end;
  logic               slot_last;
  logic               overflow;
  logic [CNT_W-1:0]   count;
  logic               box_accept;
  logic               load_en;
  logic               sort_start;
  logic               sort_done;
  logic               capture;
  logic               place_load;
  logic               place_scale;
  chain_ctl_t         ctl;
  cand_t              fetched;

  cand_t link_cand  [MAX_OUT];
  logic  link_alive [MAX_OUT];
  cand_t surv_arr   [MAX_OUT+1];
  logic  full_arr   [MAX_OUT+1];

  assign box_accept = box_valid && !box_stall;
  assign slot_end   = SLOT_W'(SLOT_W'(count) + SLOT_W'(MAX_OUT - 1));
  assign slot_last  = SLOT_W'(slot + SLOT_W'(1)) == slot_end;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.iou_threshold <= THRESH_W'(29491);
      cfg.image_width   <= LIMIT_W'(640);
      cfg.image_height  <= LIMIT_W'(640);
      cfg.inv_scale_x   <= SCALE_W'(256);
      cfg.inv_scale_y   <= SCALE_W'(256);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IOU_THRESHOLD: cfg.iou_threshold <= cfg_data;
        CFG_IMAGE_WIDTH:   cfg.image_width   <= cfg_data[LIMIT_W-1:0];
        CFG_IMAGE_HEIGHT:  cfg.image_height  <= cfg_data[LIMIT_W-1:0];
        CFG_INV_SCALE_X:   cfg.inv_scale_x   <= cfg_data;
        CFG_INV_SCALE_Y:   cfg.inv_scale_y   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD:  if (box_accept && box_item.last_box) state_next = ST_KICK;
      ST_KICK:  state_next = ST_SORT;
      ST_SORT:  if (sort_done) state_next = ST_NMS;
      ST_NMS:   if (phase == PH_DECIDE && slot_last) state_next = ST_CLAMP;
      ST_CLAMP: state_next = ST_SCALE;
      ST_SCALE: state_next = ST_SEND;
      ST_SEND: begin
        if (!res_stall) begin
          state_next = res_item.out_last ? ST_LOAD : ST_CLAMP;
        end
      end
      default:  state_next = ST_LOAD;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    box_stall   = 1'b1;
    res_valid   = 1'b0;
    load_en     = 1'b0;
    sort_start  = 1'b0;
    capture     = 1'b0;
    place_load  = 1'b0;
    place_scale = 1'b0;
    ctl.clear   = 1'b0;
    ctl.advance = 1'b0;
    ctl.shift   = 1'b0;
    ctl.phase   = phase;
    unique case (state)
      ST_LOAD: begin
        box_stall = 1'b0;
        load_en   = box_valid;
      end
      ST_KICK:  sort_start = 1'b1;
      ST_SORT: begin
      end
      ST_NMS: begin
        capture     = phase == PH_UNION;
        ctl.advance = phase == PH_DECIDE;
      end
      ST_CLAMP: begin
        place_load = 1'b1;
        ctl.shift  = 1'b1;
      end
      ST_SCALE: place_scale = 1'b1;
      ST_SEND: begin
        res_valid = 1'b1;
        ctl.clear = !res_stall && res_item.out_last;
      end
      default: begin
      end
    endcase
  end

  // State, slot timing and the overflow mark
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      phase    <= PH_EDGES;
      slot     <= '0;
      overflow <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_NMS) begin
        if (phase == PH_DECIDE) begin
          phase <= PH_EDGES;
          slot  <= slot + SLOT_W'(1);
        end else begin
          phase <= phase + PHASE_W'(1);
        end
      end else begin
        phase <= PH_EDGES;
        slot  <= '0;
      end
      if (ctl.clear) begin
        overflow <= 1'b0;
      end else if (box_accept && count == CNT_W'(MAX_BOXES)) begin
        overflow <= 1'b1;
      end
    end
  end

  scbn_store #(.MAX_BOXES(MAX_BOXES)) u_store (
    .clk        (clk),
    .rst        (rst),
    .clear      (ctl.clear),
    .load_en    (load_en),
    .load_box   (box_item),
    .count      (count),
    .sort_start (sort_start),
    .sort_done  (sort_done),
    .fetch_rank (slot[IDX_W-1:0]),
    .capture    (capture),
    .cand       (fetched)
  );

  // Chain head and tail
  assign link_cand[0]      = fetched;
  assign link_alive[0]     = SLOT_W'(count) > slot;
  assign surv_arr[MAX_OUT] = '0;
  assign full_arr[MAX_OUT] = 1'b0;

  for (genvar k = 0; k < MAX_OUT; k++) begin : g_cell
    if (k < MAX_OUT - 1) begin : g_mid
      scbn_cell u_cell (
        .clk           (clk),
        .rst           (rst),
        .ctl           (ctl),
        .iou_threshold (cfg.iou_threshold),
        .in_cand       (link_cand[k]),
        .in_alive      (link_alive[k]),
        .out_cand      (link_cand[k+1]),
        .out_alive     (link_alive[k+1]),
        .next_surv     (surv_arr[k+1]),
        .next_full     (full_arr[k+1]),
        .surv          (surv_arr[k]),
        .full          (full_arr[k])
      );
    end else begin : g_end
      scbn_cell u_cell (
        .clk           (clk),
        .rst           (rst),
        .ctl           (ctl),
        .iou_threshold (cfg.iou_threshold),
        .in_cand       (link_cand[k]),
        .in_alive      (link_alive[k]),
        .out_cand      (),
        .out_alive     (),
        .next_surv     (surv_arr[k+1]),
        .next_full     (full_arr[k+1]),
        .surv          (surv_arr[k]),
        .full          (full_arr[k])
      );
    end
  end

  scbn_place u_place (
    .clk      (clk),
    .load     (place_load),
    .scale    (place_scale),
    .surv     (surv_arr[0]),
    .last_in  (!full_arr[1]),
    .ovf_in   (overflow),
    .cfg      (cfg),
    .res_item (res_item)
  );

endmodule

`default_nettype wire

@@ hw/rtl/scbn_store.sv @@
// Box store with bit-serial LSD radix ranking by descending score and ranked fetch.
`default_nettype none

module scbn_store import scbn_pkg::*; #(
  parameter int MAX_BOXES = MAX_BOXES_DEF,
  localparam int IDX_W = $clog2(MAX_BOXES),
  localparam int CNT_W = $clog2(MAX_BOXES + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             clear,
  input  wire logic             load_en,
  input  wire box_in_t          load_box,
  output logic [CNT_W-1:0]      count,
  input  wire logic             sort_start,
  output logic                  sort_done,
  input  wire logic [IDX_W-1:0] fetch_rank,
  input  wire logic             capture,
  output cand_t                 cand
);

  box_rec_t         box_mem [MAX_BOXES];
  logic [IDX_W-1:0] order_a [MAX_BOXES];
  logic [IDX_W-1:0] order_b [MAX_BOXES];

  logic [CNT_W-1:0]  ones_cnt [SCORE_W];
  logic              room;
  logic              sorting;
  logic [PASS_W-1:0] pass;
  logic [CNT_W-1:0]  sweep;
  logic              v1;
  logic              v2;
  logic              issue;
  logic              pass_end;
  logic [IDX_W-1:0]  ptr_one;
  logic [IDX_W-1:0]  ptr_zero;
  logic [IDX_W-1:0]  id_d;
  logic [IDX_W-1:0]  a_rd;
  logic [IDX_W-1:0]  b_rd;
  logic [IDX_W-1:0]  idx1;
  logic [IDX_W-1:0]  idx2;
  logic [IDX_W-1:0]  a_raddr;
  logic [IDX_W-1:0]  box_raddr;
  logic [IDX_W-1:0]  dst_ptr;
  box_rec_t          box_rd;
  box_rec_t          load_rec;
  logic              key_bit;

  assign room     = count < CNT_W'(MAX_BOXES);
  assign issue    = sorting && (sweep < count);
  assign pass_end = sorting && !issue && !v1 && !v2;
  assign load_rec = '{left: load_box.box_left, top: load_box.box_top,
                      width: load_box.box_width, height: load_box.box_height,
                      score: load_box.box_score, cls: load_box.box_class};

  // Pick the source of this pass: arrival order first, then the previous pass
  always_comb begin
    if (pass == '0) begin
      idx1 = id_d;
    end else if (pass[0]) begin
      idx1 = b_rd;
    end else begin
      idx1 = a_rd;
    end
  end

  assign a_raddr   = sorting ? sweep[IDX_W-1:0] : fetch_rank;
  assign box_raddr = sorting ? idx1 : a_rd;
  assign key_bit   = box_rd.score[pass];
  assign dst_ptr   = key_bit ? ptr_one : ptr_zero;

  // Store each arriving box
  always_ff @(posedge clk) begin
    if (load_en && room) begin
      box_mem[count[IDX_W-1:0]] <= load_rec;
    end
  end

  // Read ports
  always_ff @(posedge clk) begin
    a_rd   <= order_a[a_raddr];
    b_rd   <= order_b[sweep[IDX_W-1:0]];
    box_rd <= box_mem[box_raddr];
    id_d   <= sweep[IDX_W-1:0];
    idx2   <= idx1;
  end

  // Scatter: ones first keeps the ranking descending, each pass is stable
  always_ff @(posedge clk) begin
    if (v2 && !pass[0]) begin
      order_b[dst_ptr] <= idx2;
    end
    if (v2 && pass[0]) begin
      order_a[dst_ptr] <= idx2;
    end
  end

  // Count, bit histograms and pass sequencing
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      count     <= '0;
      sorting   <= 1'b0;
      pass      <= '0;
      sweep     <= '0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      ptr_one   <= '0;
      ptr_zero  <= '0;
      sort_done <= 1'b0;
      for (int b = 0; b < SCORE_W; b++) begin
        ones_cnt[b] <= '0;
      end
    end else begin
      sort_done <= 1'b0;
      v1        <= issue;
      v2        <= v1;
      if (load_en && room) begin
        count <= count + CNT_W'(1);
        for (int b = 0; b < SCORE_W; b++) begin
          ones_cnt[b] <= ones_cnt[b] + CNT_W'(load_box.box_score[b]);
        end
      end
      if (sort_start) begin
        sorting  <= 1'b1;
        pass     <= '0;
        sweep    <= '0;
        ptr_one  <= '0;
        ptr_zero <= ones_cnt[0][IDX_W-1:0];
      end else begin
        if (issue) begin
          sweep <= sweep + CNT_W'(1);
        end
        if (v2) begin
          if (key_bit) begin
            ptr_one <= ptr_one + IDX_W'(1);
          end else begin
            ptr_zero <= ptr_zero + IDX_W'(1);
          end
        end
        if (pass_end) begin
          if (pass == PASS_W'(SCORE_W - 1)) begin
            sorting   <= 1'b0;
            sort_done <= 1'b1;
          end else begin
            pass     <= pass + PASS_W'(1);
            sweep    <= '0;
            ptr_one  <= '0;
            ptr_zero <= ones_cnt[PASS_W'(pass + PASS_W'(1))][IDX_W-1:0];
          end
        end
      end
    end
  end

  // Hold the fetched ranked box with its +1 pixel area
  always_ff @(posedge clk) begin
    if (capture) begin
      cand.rec  <= box_rd;
      cand.area <= (SPAN_W'(box_rd.width) + SPAN_W'(ONE_PIXEL)) *
                   (SPAN_W'(box_rd.height) + SPAN_W'(ONE_PIXEL));
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/scbn_cell.sv @@
// One suppression cell: holds a survivor and tests each passing candidate against it.
`default_nettype none

module scbn_cell import scbn_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire chain_ctl_t          ctl,
  input  wire logic [THRESH_W-1:0] iou_threshold,
  input  wire cand_t               in_cand,
  input  wire logic                in_alive,
  output cand_t                    out_cand,
  output logic                     out_alive,
  input  wire cand_t               next_surv,
  input  wire logic                next_full,
  output cand_t                    surv,
  output logic                     full
);

  cand_t                     cand;
  logic                      alive;
  logic signed [EDGE_W-1:0]  p_l, p_r, p_t, p_b;
  logic signed [EDGE_W-1:0]  q_l, q_r, q_t, q_b;
  logic signed [EDGE_W-1:0]  min_r, max_l, min_b, max_t;
  logic signed [DIFF_W-1:0]  dx, dy;
  logic [SPAN_W-1:0]         iw, ih;
  logic                      match;
  logic [AREA_W-1:0]         inter;
  logic [UNION_W-1:0]        uni;
  logic [PROD_W-1:0]         prod;
  logic                      kill;

  // Edges of the survivor and the candidate
  always_comb begin
    p_l = EDGE_W'(surv.rec.left);
    p_t = EDGE_W'(surv.rec.top);
    p_r = p_l + $signed(EDGE_W'(surv.rec.width));
    p_b = p_t + $signed(EDGE_W'(surv.rec.height));
    q_l = EDGE_W'(cand.rec.left);
    q_t = EDGE_W'(cand.rec.top);
    q_r = q_l + $signed(EDGE_W'(cand.rec.width));
    q_b = q_t + $signed(EDGE_W'(cand.rec.height));
    min_r = (p_r < q_r) ? p_r : q_r;
    max_l = (p_l > q_l) ? p_l : q_l;
    min_b = (p_b < q_b) ? p_b : q_b;
    max_t = (p_t > q_t) ? p_t : q_t;
    dx = DIFF_W'(min_r) - DIFF_W'(max_l) + DIFF_W'(ONE_PIXEL);
    dy = DIFF_W'(min_b) - DIFF_W'(max_t) + DIFF_W'(ONE_PIXEL);
  end

  // Overlap test, one step per phase of the slot
  always_ff @(posedge clk) begin
    unique case (ctl.phase)
      PH_EDGES: begin
        iw    <= dx[DIFF_W-1] ? '0 : dx[SPAN_W-1:0];
        ih    <= dy[DIFF_W-1] ? '0 : dy[SPAN_W-1:0];
        match <= surv.rec.cls == cand.rec.cls;
      end
      PH_INTER: begin
        inter <= iw * ih;
      end
      PH_UNION: begin
        uni <= UNION_W'(surv.area) + UNION_W'(cand.area) - UNION_W'(inter);
      end
      PH_PROD: begin
        prod <= iou_threshold * uni;
      end
      default: begin
      end
    endcase
  end

  assign kill      = full && alive && match && (PROD_W'({inter, 16'h0}) > prod);
  assign out_alive = alive && !kill;
  assign out_cand  = cand;

  // Claim the first live candidate, then pass the rest along; shift out at the end
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      alive <= 1'b0;
      full  <= 1'b0;
    end else if (ctl.advance) begin
      full  <= full | in_alive;
      alive <= full & in_alive;
    end else if (ctl.shift) begin
      full  <= next_full;
      alive <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      cand <= in_cand;
      if (!full && in_alive) begin
        surv <= in_cand;
      end
    end else if (ctl.shift) begin
      surv <= next_surv;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/scbn_place.sv @@
// Output stage: clamp a survivor to the image and scale its corners.
`default_nettype none

module scbn_place import scbn_pkg::*; (
  input  wire logic  clk,
  input  wire logic  load,
  input  wire logic  scale,
  input  wire cand_t surv,
  input  wire logic  last_in,
  input  wire logic  ovf_in,
  input  wire cfg_t  cfg,
  output box_out_t   res_item
);

  logic [LIMIT_W-1:0] cl, ct, cr, cb;
  logic [SCORE_W-1:0] score;
  logic [CLASS_W-1:0] cls;
  logic               ovf;
  logic               last;
  logic signed [EDGE_W-1:0] e_l, e_t, e_r, e_b;

  function automatic logic [LIMIT_W-1:0] clamp_edge(input logic signed [EDGE_W-1:0] v,
                                                    input logic [LIMIT_W-1:0] limit);
    logic signed [EDGE_W:0] lim16;
    logic [LIMIT_W-1:0]     c;
    lim16 = $signed({2'b00, limit, 4'h0});
    if (v <= 0) begin
      c = '0;
    end else if ((EDGE_W+1)'(v) >= lim16) begin
      c = limit;
    end else begin
      c = v[LIMIT_W+3:4];
    end
    return c;
  endfunction

  function automatic logic [OUT_W-1:0] scale_edge(input logic [LIMIT_W-1:0] c,
                                                  input logic [SCALE_W-1:0] inv);
    logic [LIMIT_W+SCALE_W-1:0] p;
    logic [LIMIT_W+SCALE_W-9:0] s;
    p = c * inv;
    s = p[LIMIT_W+SCALE_W-1:8];
    return (s > (LIMIT_W+SCALE_W-8)'({OUT_W{1'b1}})) ? {OUT_W{1'b1}} : s[OUT_W-1:0];
  endfunction

  assign e_l = EDGE_W'(surv.rec.left);
  assign e_t = EDGE_W'(surv.rec.top);
  assign e_r = e_l + $signed(EDGE_W'(surv.rec.width));
  assign e_b = e_t + $signed(EDGE_W'(surv.rec.height));

  // Clamp stage
  always_ff @(posedge clk) begin
    if (load) begin
      cl    <= clamp_edge(e_l, cfg.image_width);
      ct    <= clamp_edge(e_t, cfg.image_height);
      cr    <= clamp_edge(e_r, cfg.image_width);
      cb    <= clamp_edge(e_b, cfg.image_height);
      score <= surv.rec.score;
      cls   <= surv.rec.cls;
      ovf   <= ovf_in;
      last  <= last_in;
    end
  end

  // Scale stage, held until the item is taken
  always_ff @(posedge clk) begin
    if (scale) begin
      res_item.out_left       <= scale_edge(cl, cfg.inv_scale_x);
      res_item.out_top        <= scale_edge(ct, cfg.inv_scale_y);
      res_item.out_right      <= scale_edge(cr, cfg.inv_scale_x);
      res_item.out_bottom     <= scale_edge(cb, cfg.inv_scale_y);
      res_item.out_score      <= score;
      res_item.out_class      <= cls;
      res_item.out_overflowed <= ovf;
      res_item.out_last       <= last;
    end
  end

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for the class-wise greedy box suppression block.
`default_nettype none

module testbench;
  import scbn_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BATCH_CAP    = 1024;
  localparam int SURVIVOR_CAP = 64;
  localparam int STALL_LIMIT  = 20000;
  localparam int IN_BITS      = $bits(box_in_t);
  localparam longint OUT_SAT  = 64'd1048575;

  typedef struct {
    box_in_t  box;
    bit       typed;
    box_out_t want;
  } dir_row_t;

  logic clk;
  logic rst;
  logic box_valid;
  logic box_stall;
  box_in_t box_item;
  logic res_valid;
  logic res_stall;
  box_out_t res_item;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  sorted_classwise_box_nms u_dut (
    .clk(clk), .rst(rst),
    .box_valid(box_valid), .box_stall(box_stall), .box_item(box_item),
    .res_valid(res_valid), .res_stall(res_stall), .res_item(res_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow registers
  longint thr_q16, img_w, img_h, scale_x, scale_y;

  // Shadow of the batch being loaded
  box_in_t batch_box [BATCH_CAP];
  int      batch_len = 0;
  bit      batch_dropped = 1'b0;

  box_out_t survivors_due[$];
  bit       typed_pending;
  box_out_t typed_want;

  int  err_count = 0;
  int  items_sent = 0;
  int  batches_done = 0;
  int  results_seen = 0;
  int  idle_pct;
  int  stall_pct;
  int  quiet_cycles = 0;

  dir_row_t dir_rows[$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Overlap test with the +1 pixel convention, exact integer compare
  function automatic bit overlaps_past(box_in_t p, box_in_t q);
    longint pl, pt, pr, pb, ql, qt, qr, qb, iw, ih, inter, a0, a1, uni;
    pl = longint'($signed(p.box_left));
    pt = longint'($signed(p.box_top));
    ql = longint'($signed(q.box_left));
    qt = longint'($signed(q.box_top));
    pr = pl + longint'(p.box_width);
    pb = pt + longint'(p.box_height);
    qr = ql + longint'(q.box_width);
    qb = qt + longint'(q.box_height);
    iw = ((pr < qr) ? pr : qr) - ((pl > ql) ? pl : ql) + ONE_PIXEL;
    ih = ((pb < qb) ? pb : qb) - ((pt > qt) ? pt : qt) + ONE_PIXEL;
    if (iw < 0) iw = 0;
    if (ih < 0) ih = 0;
    inter = iw * ih;
    a0 = (longint'(p.box_width) + ONE_PIXEL) * (longint'(p.box_height) + ONE_PIXEL);
    a1 = (longint'(q.box_width) + ONE_PIXEL) * (longint'(q.box_height) + ONE_PIXEL);
    uni = a0 + a1 - inter;
    if (uni == 0) return 1'b0;
    return (inter * 65536) > (thr_q16 * uni);
  endfunction

  // Clamp an edge to the image, truncate to pixels, scale and saturate
  function automatic logic [OUT_W-1:0] place_edge(longint v, longint limit, longint inv);
    longint c;
    if (v <= 0) c = 0;
    else if (v >= limit * ONE_PIXEL) c = limit;
    else c = v >>> 4;
    c = (c * inv) >>> 8;
    if (c > OUT_SAT) c = OUT_SAT;
    return c[OUT_W-1:0];
  endfunction

  // Rank, suppress and queue the survivors of the loaded batch
  task automatic predict_survivors();
    int order [BATCH_CAP];
    bit gone [BATCH_CAP];
    int picks[$];
    int rank, a, c;
    box_in_t b;
    box_out_t o;
    longint l, t;
    for (int i = 0; i < batch_len; i++) begin
      rank = 0;
      gone[i] = 1'b0;
      for (int j = 0; j < batch_len; j++) begin
        if (batch_box[j].box_score > batch_box[i].box_score ||
            (batch_box[j].box_score == batch_box[i].box_score && j < i)) rank++;
      end
      order[rank] = i;
    end
    for (int i = 0; i < batch_len; i++) begin
      a = order[i];
      if (!gone[a]) begin
        for (int j = i + 1; j < batch_len; j++) begin
          c = order[j];
          if (!gone[c] && batch_box[a].box_class == batch_box[c].box_class &&
              overlaps_past(batch_box[a], batch_box[c])) gone[c] = 1'b1;
        end
      end
    end
    for (int i = 0; i < batch_len && picks.size() < SURVIVOR_CAP; i++) begin
      if (!gone[order[i]]) picks.insert(picks.size(), order[i]);
    end
    foreach (picks[k]) begin
      b = batch_box[picks[k]];
      l = longint'($signed(b.box_left));
      t = longint'($signed(b.box_top));
      o.out_left = place_edge(l, img_w, scale_x);
      o.out_top = place_edge(t, img_h, scale_y);
      o.out_right = place_edge(l + longint'(b.box_width), img_w, scale_x);
      o.out_bottom = place_edge(t + longint'(b.box_height), img_h, scale_y);
      o.out_score = b.box_score;
      o.out_class = b.box_class;
      o.out_overflowed = batch_dropped;
      o.out_last = (k == picks.size() - 1);
      survivors_due.insert(survivors_due.size(), o);
    end
  endtask

  // Capture accepted boxes; a last box closes the batch
  always @(posedge clk) begin
    if (!rst && box_valid && !box_stall) begin
      items_sent++;
      if (batch_len < BATCH_CAP) begin
        batch_box[batch_len] = box_item;
        batch_len++;
      end else begin
        batch_dropped = 1'b1;
      end
      if (box_item.last_box) begin
        if (typed_pending) begin
          survivors_due.insert(survivors_due.size(), typed_want);
        end else begin
          predict_survivors();
        end
        batch_len = 0;
        batch_dropped = 1'b0;
        batches_done++;
      end
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    box_out_t w;
    if (!rst && res_valid && !res_stall) begin
      results_seen++;
      if (survivors_due.size() == 0) begin
        $error("unexpected result %p", res_item);
        err_count++;
      end else begin
        w = survivors_due.pop_front();
        if (res_item.out_left !== w.out_left) begin
          $error("out_left expected %0d got %0d", w.out_left, res_item.out_left);
          err_count++;
        end
        if (res_item.out_top !== w.out_top) begin
          $error("out_top expected %0d got %0d", w.out_top, res_item.out_top);
          err_count++;
        end
        if (res_item.out_right !== w.out_right) begin
          $error("out_right expected %0d got %0d", w.out_right, res_item.out_right);
          err_count++;
        end
        if (res_item.out_bottom !== w.out_bottom) begin
          $error("out_bottom expected %0d got %0d", w.out_bottom, res_item.out_bottom);
          err_count++;
        end
        if (res_item.out_score !== w.out_score) begin
          $error("out_score expected %0d got %0d", w.out_score, res_item.out_score);
          err_count++;
        end
        if (res_item.out_class !== w.out_class) begin
          $error("out_class expected %0d got %0d", w.out_class, res_item.out_class);
          err_count++;
        end
        if (res_item.out_overflowed !== w.out_overflowed) begin
          $error("out_overflowed expected %0d got %0d", w.out_overflowed,
                 res_item.out_overflowed);
          err_count++;
        end
        if (res_item.out_last !== w.out_last) begin
          $error("out_last expected %0d got %0d", w.out_last, res_item.out_last);
          err_count++;
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((box_valid && !box_stall) || (res_valid && !res_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("sorted_classwise_box_nms verification failed");
      $finish;
    end
  end

  // Random receiver stall
  always @(negedge clk) begin
    res_stall <= ($urandom_range(99) < stall_pct);
  end

  // Add one row to the directed table
  task automatic add_row(box_in_t b, bit typed, box_out_t want);
    dir_row_t row;
    row.box = b;
    row.typed = typed;
    row.want = want;
    dir_rows.insert(dir_rows.size(), row);
  endtask

  // Drive one box and hold it until taken
  task automatic send_box(box_in_t b);
    while ($urandom_range(99) < idle_pct) begin
      box_valid = 1'b0;
      @(negedge clk);
    end
    box_valid = 1'b1;
    box_item = b;
    @(posedge clk);
    while (box_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Hold off until every result is in, then let the block settle
  task automatic drain();
    box_valid = 1'b0;
    while (survivors_due.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val[CFG_DATA_W-1:0];
    case (idx)
      CFG_IOU_THRESHOLD: thr_q16 = val & 16'hFFFF;
      CFG_IMAGE_WIDTH:   img_w = val & 13'h1FFF;
      CFG_IMAGE_HEIGHT:  img_h = val & 13'h1FFF;
      CFG_INV_SCALE_X:   scale_x = val & 16'hFFFF;
      CFG_INV_SCALE_Y:   scale_y = val & 16'hFFFF;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic write_all(int thr, int w, int h, int sx, int sy);
    write_reg(CFG_IOU_THRESHOLD, thr);
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
    write_reg(CFG_INV_SCALE_X, sx);
    write_reg(CFG_INV_SCALE_Y, sy);
  endtask

  // Clustered batches with some fully random boxes mixed in
  task automatic random_batches(int quota);
    int stop_at, size, cx, cy;
    box_in_t b;
    stop_at = items_sent + quota;
    while (items_sent < stop_at) begin
      size = $urandom_range(1, 10);
      cx = $urandom_range(0, 12000);
      cy = $urandom_range(0, 12000);
      for (int k = 0; k < size; k++) begin
        if ($urandom_range(99) < 15) begin
          b = box_in_t'(IN_BITS'({$urandom, $urandom, $urandom}));
        end else begin
          b.box_left = COORD_W'(cx + $urandom_range(0, 128) - 64);
          b.box_top = COORD_W'(cy + $urandom_range(0, 128) - 64);
          b.box_width = COORD_W'($urandom_range(200, 2000));
          b.box_height = COORD_W'($urandom_range(200, 2000));
          b.box_score = SCORE_W'($urandom);
          b.box_class = ($urandom_range(9) == 0) ? CLASS_W'($urandom_range(0, 127))
                                                  : CLASS_W'($urandom_range(0, 3));
        end
        b.last_box = (k == size - 1);
        send_box(b);
      end
    end
  endtask

  // Batch with more surviving classes than the output cap
  task automatic wide_batch(int size, bit distinct_cls);
    box_in_t b;
    for (int k = 0; k < size; k++) begin
      b = box_in_t'(IN_BITS'({$urandom, $urandom, $urandom}));
      if (distinct_cls) b.box_class = CLASS_W'(k);
      b.last_box = (k == size - 1);
      send_box(b);
    end
  endtask

  initial begin
    rst = 1'b1;
    box_valid = 1'b0;
    box_item = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    typed_pending = 1'b0;
    thr_q16 = 29491;
    img_w = 640;
    img_h = 640;
    scale_x = 256;
    scale_y = 256;
    idle_pct = 12;
    stall_pct = 87;

    // Single-box batches read off directly at reset settings
    add_row('{16'sd160, 16'sd320, 16'd480, 16'd640, 16'd1000, 7'd3, 1'b1},
            1'b1, '{20'd10, 20'd20, 20'd40, 20'd60, 16'd1000, 7'd3, 1'b0, 1'b1});
    add_row('{-16'sd32768, -16'sd32768, 16'hFFFF, 16'hFFFF, 16'hFFFF, 7'd127, 1'b1},
            1'b1, '{20'd0, 20'd0, 20'd640, 20'd640, 16'hFFFF, 7'd127, 1'b0, 1'b1});
    add_row('{16'sd32767, 16'sd32767, 16'd0, 16'd0, 16'd0, 7'd0, 1'b1},
            1'b1, '{20'd640, 20'd640, 20'd640, 20'd640, 16'd0, 7'd0, 1'b0, 1'b1});
    add_row('{16'sd15, 16'sd15, 16'd1, 16'd1, 16'd1, 7'd79, 1'b1},
            1'b1, '{20'd0, 20'd0, 20'd1, 20'd1, 16'd1, 7'd79, 1'b0, 1'b1});
    // Duplicates with tied scores, other class, partial overlap, far box,
    // class past the class count, zero-size box
    add_row('{16'sd800, 16'sd800, 16'd800, 16'd800, 16'd5000, 7'd1, 1'b0}, 1'b0, '0);
    add_row('{16'sd800, 16'sd800, 16'd800, 16'd800, 16'd5000, 7'd1, 1'b0}, 1'b0, '0);
    add_row('{16'sd800, 16'sd800, 16'd800, 16'd800, 16'd5000, 7'd2, 1'b0}, 1'b0, '0);
    add_row('{16'sd900, 16'sd900, 16'd800, 16'd800, 16'd4000, 7'd1, 1'b0}, 1'b0, '0);
    add_row('{16'sd1100, 16'sd1100, 16'd800, 16'd800, 16'd4500, 7'd1, 1'b0}, 1'b0, '0);
    add_row('{16'sd8000, 16'sd8000, 16'd160, 16'd160, 16'd6000, 7'd1, 1'b0}, 1'b0, '0);
    add_row('{16'sd800, 16'sd800, 16'd800, 16'd800, 16'd7000, 7'd100, 1'b0}, 1'b0, '0);
    add_row('{16'sd0, 16'sd0, 16'd0, 16'd0, 16'd0, 7'd1, 1'b1}, 1'b0, '0);
    // Score order check
    add_row('{16'sd16, 16'sd16, 16'd32, 16'd32, 16'd10, 7'd5, 1'b0}, 1'b0, '0);
    add_row('{16'sd320, 16'sd16, 16'd32, 16'd32, 16'hFFFF, 7'd5, 1'b0}, 1'b0, '0);
    add_row('{16'sd640, 16'sd16, 16'd32, 16'd32, 16'd300, 7'd5, 1'b0}, 1'b0, '0);
    add_row('{16'sd960, 16'sd16, 16'd32, 16'd32, 16'd300, 7'd5, 1'b1}, 1'b0, '0);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Phase one: directed table at reset settings, then an extreme setting
    foreach (dir_rows[r]) begin
      typed_pending = dir_rows[r].typed;
      typed_want = dir_rows[r].want;
      send_box(dir_rows[r].box);
    end
    typed_pending = 1'b0;
    drain();
    write_all(0, 1, 4096, 65535, 0);
    random_batches(4);
    drain();

    // Phase two: receiver idles little, other extreme plus the output cap
    idle_pct = 87;
    stall_pct = 12;
    write_all(65535, 4096, 1, 128, 512);
    random_batches(4);
    wide_batch(65, 1'b1);
    drain();

    // Phase three: full rate, random settings, then reset settings again
    idle_pct = 0;
    stall_pct = 0;
    write_all($urandom_range(0, 65535), $urandom_range(1, 4096), $urandom_range(1, 4096),
              $urandom_range(0, 65535), $urandom_range(0, 65535));
    random_batches(6);
    drain();
    write_all(29491, 640, 640, 256, 256);
    random_batches(6);
    drain();

    $display("Sent %0d boxes in %0d batches and checked %0d survivors,", items_sent,
             batches_done, results_seen);
    $display("under reset, extreme and random settings, three idle patterns and the output cap.");
    if (err_count == 0) begin
      $display("sorted_classwise_box_nms verification clean");
    end else begin
      $display("sorted_classwise_box_nms verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
